/* sv/fhc_pkg.sv */
// ----------------------------------------------------------------------------
// fhc_pkg
// Shared types, header layout constants and verdict codes for the frame
// header checker.
// ----------------------------------------------------------------------------
package fhc_pkg;

  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned HDR_BYTES = 24;

  // Byte offsets of the header fields.
  localparam logic [4:0] MAGIC_BASE   = 5'd0;
  localparam logic [4:0] VERSION_BASE = 5'd4;
  localparam logic [4:0] OPCODE_BASE  = 5'd6;
  localparam logic [4:0] REQUEST_BASE = 5'd8;
  localparam logic [4:0] STATUS_BASE  = 5'd12;
  localparam logic [4:0] RSVD_BASE    = 5'd16;
  localparam logic [4:0] LENGTH_BASE  = 5'd20;

  localparam logic [7:0] MAGIC [4] = '{8'h5A, 8'h43, 8'h4C, 8'h31};

  localparam logic [15:0] VERSION_RESET = 16'd1;

  // Verdict codes.
  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_SHORT    = 3'd1;
  localparam logic [2:0] ERR_MAGIC    = 3'd2;
  localparam logic [2:0] ERR_VERSION  = 3'd3;
  localparam logic [2:0] ERR_RESERVED = 3'd4;
  localparam logic [2:0] ERR_OVERRUN  = 3'd5;

  // Header state after a byte has been absorbed.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               magic_bad;
    logic               rsvd_bad;
    logic [15:0]        version;
    logic [15:0]        opcode;
    logic [31:0]        request;
    logic [31:0]        status;
    logic [31:0]        length;
  } hdr_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  error_code;
    logic [15:0] version_field;
    logic [15:0] opcode_field;
    logic [31:0] request_id;
    logic [31:0] status_word;
    logic [31:0] payload_length;
  } result_t;

endpackage

/* sv/fhc_byte_if.sv */
// ----------------------------------------------------------------------------
// fhc_byte_if
// Byte stream channel: one buffer byte per transfer, flag on the last byte.
// ----------------------------------------------------------------------------
interface fhc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

/* sv/fhc_result_if.sv */
// ----------------------------------------------------------------------------
// fhc_result_if
// Verdict channel: one transfer per buffer with the decoded header fields.
// ----------------------------------------------------------------------------
interface fhc_result_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [2:0]  error_code;
  logic [15:0] version_field;
  logic [15:0] opcode_field;
  logic [31:0] request_id;
  logic [31:0] status_word;
  logic [31:0] payload_length;

  modport source (output valid, output accepted, output error_code,
                  output version_field, output opcode_field, output request_id,
                  output status_word, output payload_length, input ready);
  modport sink   (input valid, input accepted, input error_code,
                  input version_field, input opcode_field, input request_id,
                  input status_word, input payload_length, output ready);
endinterface

/* sv/fhc_accum.sv */
// ----------------------------------------------------------------------------
// fhc_accum
// Header accumulator: saturating byte counter, magic and reserved flags and
// the little-endian field holds. Presents the state after the current byte.
// ----------------------------------------------------------------------------
module fhc_accum (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    byte_value,
  input  logic          last_byte,
  output fhc_pkg::hdr_t view
);
  import fhc_pkg::*;

  logic [COUNT_W-1:0] count_r;
  logic               magic_bad_r;
  logic               rsvd_bad_r;
  logic [15:0]        version_r;
  logic [15:0]        opcode_r;
  logic [31:0]        request_r;
  logic [31:0]        status_r;
  logic [31:0]        length_r;

  logic               in_hdr;
  logic [4:0]         pos;
  logic [4:0]         sub;

  assign in_hdr = (count_r < COUNT_W'(HDR_BYTES));
  assign pos    = count_r[4:0];

  always_comb begin
    view.count     = (count_r == {COUNT_W{1'b1}}) ? count_r : count_r + 1'b1;
    view.magic_bad = magic_bad_r;
    view.rsvd_bad  = rsvd_bad_r;
    view.version   = version_r;
    view.opcode    = opcode_r;
    view.request   = request_r;
    view.status    = status_r;
    view.length    = length_r;
    sub            = 5'd0;
    if (in_hdr) begin
      if (pos < VERSION_BASE) begin
        sub = pos - MAGIC_BASE;
        if (byte_value != MAGIC[sub[1:0]]) begin
          view.magic_bad = 1'b1;
        end
      end else if (pos < OPCODE_BASE) begin
        sub = pos - VERSION_BASE;
        view.version[8*sub[0] +: 8] = byte_value;
      end else if (pos < REQUEST_BASE) begin
        sub = pos - OPCODE_BASE;
        view.opcode[8*sub[0] +: 8] = byte_value;
      end else if (pos < STATUS_BASE) begin
        sub = pos - REQUEST_BASE;
        view.request[8*sub[1:0] +: 8] = byte_value;
      end else if (pos < RSVD_BASE) begin
        sub = pos - STATUS_BASE;
        view.status[8*sub[1:0] +: 8] = byte_value;
      end else if (pos < LENGTH_BASE) begin
        if (byte_value != 8'd0) begin
          view.rsvd_bad = 1'b1;
        end
      end else begin
        sub = pos - LENGTH_BASE;
        view.length[8*sub[1:0] +: 8] = byte_value;
      end
    end
  end

  // The counter and the flags restart after the last byte. The holds need no
  // clearing: every header byte is rewritten before a buffer counts as full.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      magic_bad_r <= 1'b0;
      rsvd_bad_r  <= 1'b0;
    end else if (step) begin
      if (last_byte) begin
        count_r     <= '0;
        magic_bad_r <= 1'b0;
        rsvd_bad_r  <= 1'b0;
      end else begin
        count_r     <= view.count;
        magic_bad_r <= view.magic_bad;
        rsvd_bad_r  <= view.rsvd_bad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      version_r <= view.version;
      opcode_r  <= view.opcode;
      request_r <= view.request;
      status_r  <= view.status;
      length_r  <= view.length;
    end
  end

endmodule

/* sv/fhc_verdict.sv */
// ----------------------------------------------------------------------------
// fhc_verdict
// Ordered header checks on the accumulated state and the reported fields.
// ----------------------------------------------------------------------------
module fhc_verdict (
  input  fhc_pkg::hdr_t    hdr,
  input  logic [15:0]      expected_version,
  output fhc_pkg::result_t res
);
  import fhc_pkg::*;

  logic        full;
  logic        overrun;
  logic [32:0] needed;

  assign full    = (hdr.count >= COUNT_W'(HDR_BYTES));
  assign needed  = {1'b0, hdr.length} + 33'(HDR_BYTES);
  assign overrun = (needed > {1'b0, hdr.count});

  always_comb begin
    if (!full) begin
      res.error_code = ERR_SHORT;
    end else if (hdr.magic_bad) begin
      res.error_code = ERR_MAGIC;
    end else if (hdr.version != expected_version) begin
      res.error_code = ERR_VERSION;
    end else if (hdr.rsvd_bad) begin
      res.error_code = ERR_RESERVED;
    end else if (overrun) begin
      res.error_code = ERR_OVERRUN;
    end else begin
      res.error_code = ERR_OK;
    end
    res.accepted       = (res.error_code == ERR_OK);
    res.version_field  = full ? hdr.version : 16'd0;
    res.opcode_field   = full ? hdr.opcode  : 16'd0;
    res.request_id     = full ? hdr.request : 32'd0;
    res.status_word    = full ? hdr.status  : 32'd0;
    res.payload_length = full ? hdr.length  : 32'd0;
  end

endmodule

/* sv/frame_header_checker.sv */
// ----------------------------------------------------------------------------
// frame_header_checker
// Checks a 24-byte little-endian frame header streamed one byte per
// transfer and reports one verdict with the decoded fields per buffer.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Per transfer
//  ---------+-----------+------------------------------------------------
//  in_ch    | sink      | one buffer byte and its last-byte flag
//  out_ch   | source    | verdict, error code and header fields
//  cfg_*    | write     | expected version, 16 bits, no read-back
//
// One byte per cycle sustained unless a last byte waits on a stalled verdict:
// a byte sits in the input register while the accumulator and the check
// logic work on it, and the verdict is registered in the result register as
// the last byte leaves the input register. Reset clears the counter, the
// flags and both valid bits, and sets the expected version to 1. A stalled
// verdict holds only a last byte in the input register; other bytes go on.
module frame_header_checker (
  input  logic        clk,
  input  logic        rst_n,
  fhc_byte_if.sink    in_ch,
  fhc_result_if.source out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import fhc_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        out_valid_r;
  result_t     result_r;
  logic [15:0] expected_version_r;

  logic        out_free;
  logic        advance;
  logic        load;
  hdr_t        hdr_view;
  result_t     verdict;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = s1_valid_r && (!s1_last_r || out_free);
  assign load        = advance && s1_last_r;
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_version_r <= VERSION_RESET;
    end else if (cfg_we) begin
      expected_version_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.byte_value;
      s1_last_r <= in_ch.last_byte;
    end
  end

  fhc_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .byte_value (s1_byte_r),
    .last_byte  (s1_last_r),
    .view       (hdr_view)
  );

  fhc_verdict u_verdict (
    .hdr              (hdr_view),
    .expected_version (expected_version_r),
    .res              (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= verdict;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.accepted       = result_r.accepted;
  assign out_ch.error_code     = result_r.error_code;
  assign out_ch.version_field  = result_r.version_field;
  assign out_ch.opcode_field   = result_r.opcode_field;
  assign out_ch.request_id     = result_r.request_id;
  assign out_ch.status_word    = result_r.status_word;
  assign out_ch.payload_length = result_r.payload_length;

`ifndef NO_ASSERTIONS
  a_accept_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.accepted |-> out_ch.error_code == ERR_OK)
    else $error("accepted verdict with nonzero error code");

  a_short_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.error_code == ERR_SHORT |->
      out_ch.payload_length == 32'd0 && out_ch.request_id == 32'd0 &&
      out_ch.version_field == 16'd0)
    else $error("short buffer verdict carries header fields");

  a_last_gives_verdict : assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("last byte did not produce a verdict");

  a_stall_holds_last : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_last_r && out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while a last byte waits on a full result register");
`endif

endmodule
